// File: hdl/line_clipper_defines.svh
// Assertion macros shared by the line clipper RTL.
`ifndef LINE_CLIPPER_DEFINES_SVH
`define LINE_CLIPPER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define LC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define LC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, live through reset.
`define LC_ASSERT_NXT_NR(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/lc_pkg.sv
// Shared constants and types of the line clipper.
package lc_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int WIN_BITS       = 12;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 4;

    localparam logic [WIN_BITS-1:0] LEFT_RST   = 12'd0;
    localparam logic [WIN_BITS-1:0] RIGHT_RST  = 12'd639;
    localparam logic [WIN_BITS-1:0] TOP_RST    = 12'd0;
    localparam logic [WIN_BITS-1:0] BOTTOM_RST = 12'd479;

    // outcode bit positions
    localparam int CODE_N = 3;
    localparam int CODE_S = 2;
    localparam int CODE_E = 1;
    localparam int CODE_W = 0;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_TOP    = 2'd2,
        REG_BOTTOM = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [WIN_BITS-1:0] left;
        logic [WIN_BITS-1:0] right;
        logic [WIN_BITS-1:0] top;
        logic [WIN_BITS-1:0] bottom;
    } t_window;
endpackage

// File: hdl/lc_if.sv
// Segment and clipped-segment channel interfaces.
interface lc_seg_if #(parameter int COORD_BITS = lc_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lc_clip_if #(parameter int COORD_BITS = lc_pkg::COORD_BITS_DEF);
    logic                         valid;
    logic                         ready;
    logic                         visible;
    logic signed [COORD_BITS-1:0] clipped_start_x;
    logic signed [COORD_BITS-1:0] clipped_start_y;
    logic signed [COORD_BITS-1:0] clipped_end_x;
    logic signed [COORD_BITS-1:0] clipped_end_y;
    modport source (output valid, visible, clipped_start_x, clipped_start_y,
                    clipped_end_x, clipped_end_y, input ready);
    modport sink (input valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, output ready);
endinterface

// File: hdl/line_clipper.sv
// Line clipper top level: outcode, border crossing and reject pipeline.
//
// Usage:
//   i_seg carries one segment word (start_x, start_y, end_x, end_y) per
//   valid/ready handshake; o_clip returns one word per segment with the
//   visible flag and the clipped endpoints, or the input endpoints when the
//   segment is rejected. The window (left, right, top, bottom) is written over
//   the APB port at byte addresses 0, 4, 8 and 12; the user must write it only
//   while no segment is in flight, as the block does not enforce this.
//   The four restoring dividers, one quotient bit per stage, set the
//   pipeline depth.
//   Throughput: one segment per cycle while no o_clip word waits untaken;
//   every stage advances together.
//   Stall: while o_clip holds a word that is not taken, the whole pipeline
//   holds and i_seg.ready drops; no word is lost or repeated.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   window with 0, 639, 0, 479.
`include "line_clipper_defines.svh"

module line_clipper #(
    parameter int COORD_BITS = lc_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lc_seg_if.sink                           i_seg,
    lc_clip_if.source                        o_clip,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [lc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [lc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                             pready
);
    localparam int W  = COORD_BITS;
    localparam int WB = lc_pkg::WIN_BITS;
    localparam int CW = ((W > WB) ? W : WB) + 1;   // compare width
    localparam int DW = CW + 1;                    // border distance
    localparam int EW = W + 1;                     // endpoint delta
    localparam int PW = DW + EW;                   // product
    localparam int NW = PW;                        // numerator / quotient magnitude
    localparam int SW = NW + 2;                    // crossing sum
    localparam int CN = lc_pkg::CODE_N;
    localparam int CS = lc_pkg::CODE_S;
    localparam int CE = lc_pkg::CODE_E;
    localparam int CWB = lc_pkg::CODE_W;

    typedef struct packed {
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
        logic signed [W-1:0] x2;
        logic signed [W-1:0] y2;
        logic [3:0]          c1;
        logic [3:0]          c2;
        logic [3:0]          neg;    // per division: h1, v1, h2, v2
        logic [3:0]          zero;
    } t_meta;

    function automatic logic signed [SW-1:0] f_ext_sw(input logic [WB-1:0] v);
        return $signed({{(SW-WB){1'b0}}, v});
    endfunction

    function automatic logic signed [DW-1:0] f_ext_dw(input logic [WB-1:0] v);
        return $signed({{(DW-WB){1'b0}}, v});
    endfunction

    function automatic logic [3:0] f_outcode(input logic signed [W-1:0] x,
                                             input logic signed [W-1:0] y,
                                             input lc_pkg::t_window win);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic [3:0]           c;
        xs = CW'(x);
        ys = CW'(y);
        c  = '0;
        if (ys < $signed({{(CW-WB){1'b0}}, win.top})) c[CN] = 1'b1;
        else if (ys > $signed({{(CW-WB){1'b0}}, win.bottom})) c[CS] = 1'b1;
        if (xs < $signed({{(CW-WB){1'b0}}, win.left})) c[CWB] = 1'b1;
        else if (xs > $signed({{(CW-WB){1'b0}}, win.right})) c[CE] = 1'b1;
        return c;
    endfunction

    function automatic logic f_inside(input logic signed [SW-1:0] x,
                                      input logic signed [SW-1:0] y,
                                      input lc_pkg::t_window win);
        return (x >= f_ext_sw(win.left)) && (x <= f_ext_sw(win.right)) &&
               (y >= f_ext_sw(win.top)) && (y <= f_ext_sw(win.bottom));
    endfunction

    lc_pkg::t_window w_win;
    logic            w_en;

    lc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_win   (w_win)
    );

    // Whole pipeline advances unless the output word is held.
    logic r_out_valid;
    assign w_en        = !r_out_valid || o_clip.ready;
    assign i_seg.ready = w_en;

    // Stage valids.
    logic          r_v1, r_v2, r_v3, r_v4, r_vb1, r_vb2;
    logic [NW-1:0] r_vd;

    // Stage payloads.
    t_meta n_m1, r_m1, r_m2, r_m3, n_m4, r_m4, r_mb1, r_mb2;
    t_meta r_md [NW];

    logic signed [DW-1:0] n_nh1, n_nh2, n_nv1, n_nv2;
    logic signed [DW-1:0] r_nh1, r_nh2, r_nv1, r_nv2;
    logic signed [EW-1:0] n_dx, n_dy, r_dx, r_dy, r_dx3, r_dy3;
    logic signed [PW-1:0] w_p [4];
    logic signed [PW-1:0] r_p [4];
    logic [NW-1:0]        n_mag [4];
    logic [NW-1:0]        r_mag [4];
    logic [EW-1:0]        r_dmx, r_dmy;
    logic [NW-1:0]        w_quot [4];
    logic signed [SW-1:0] n_s [4];
    logic signed [SW-1:0] r_s [4];
    logic signed [SW-1:0] n_px [2];
    logic signed [SW-1:0] n_py [2];
    logic signed [SW-1:0] r_px [2];
    logic signed [SW-1:0] r_py [2];

    logic                n_vis, r_vis;
    logic signed [W-1:0] n_o [4];
    logic signed [W-1:0] r_o [4];
    logic [3:0]          r_c1o, r_c2o;

    // Valid chain: clear on reset, advance on enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_vd        <= '0;
            r_vb1       <= 1'b0;
            r_vb2       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= i_seg.valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_vd        <= {r_vd[NW-2:0], r_v4};
            r_vb1       <= r_vd[NW-1];
            r_vb2       <= r_vb1;
            r_out_valid <= r_vb2;
        end
    end

    // Stage 1: capture endpoints and outcodes.
    always_comb begin
        n_m1      = '0;
        n_m1.x1   = i_seg.start_x;
        n_m1.y1   = i_seg.start_y;
        n_m1.x2   = i_seg.end_x;
        n_m1.y2   = i_seg.end_y;
        n_m1.c1   = f_outcode(i_seg.start_x, i_seg.start_y, w_win);
        n_m1.c2   = f_outcode(i_seg.end_x, i_seg.end_y, w_win);
    end

    // Stage 2: border distances and deltas. The second endpoint shares dx, dy:
    // both numerator and divisor flip sign, which a truncating quotient ignores.
    always_comb begin
        n_nh1 = f_ext_dw(r_m1.c1[CN] ? w_win.top : w_win.bottom) - DW'($signed(r_m1.y1));
        n_nh2 = f_ext_dw(r_m1.c2[CN] ? w_win.top : w_win.bottom) - DW'($signed(r_m1.y2));
        n_nv1 = f_ext_dw(r_m1.c1[CWB] ? w_win.left : w_win.right) - DW'($signed(r_m1.x1));
        n_nv2 = f_ext_dw(r_m1.c2[CWB] ? w_win.left : w_win.right) - DW'($signed(r_m1.x2));
        n_dx  = EW'($signed(r_m1.x2)) - EW'($signed(r_m1.x1));
        n_dy  = EW'($signed(r_m1.y2)) - EW'($signed(r_m1.y1));
    end

    // Stage 3: products.
    assign w_p[0] = r_nh1 * r_dx;
    assign w_p[1] = r_nv1 * r_dy;
    assign w_p[2] = r_nh2 * r_dx;
    assign w_p[3] = r_nv2 * r_dy;

    // Stage 4: magnitudes, quotient signs and zero divisors.
    always_comb begin
        n_m4 = r_m3;
        for (int k = 0; k < 4; k++) begin
            n_mag[k] = NW'(r_p[k][PW-1] ? -r_p[k] : r_p[k]);
        end
        n_m4.neg[0]  = r_p[0][PW-1] ^ r_dy3[EW-1];
        n_m4.neg[1]  = r_p[1][PW-1] ^ r_dx3[EW-1];
        n_m4.neg[2]  = r_p[2][PW-1] ^ r_dy3[EW-1];
        n_m4.neg[3]  = r_p[3][PW-1] ^ r_dx3[EW-1];
        n_m4.zero[0] = (r_dy3 == '0);
        n_m4.zero[1] = (r_dx3 == '0);
        n_m4.zero[2] = (r_dy3 == '0);
        n_m4.zero[3] = (r_dx3 == '0);
    end

    genvar k;
    for (k = 0; k < 4; k++) begin : g_div
        lc_div_pipe #(
            .NUM_BITS (NW),
            .DEN_BITS (EW)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_mag[k]),
            .i_den  (((k % 2) == 0) ? r_dmy : r_dmx),
            .o_quot (w_quot[k])
        );
    end

    // Stage B1: signed quotient, add own coordinate, bias negative sums by one.
    always_comb begin
        logic signed [SW-1:0] q;
        logic signed [SW-1:0] a;
        logic signed [SW-1:0] s;
        for (int i = 0; i < 4; i++) begin
            unique case (i)
                0:       a = SW'($signed(r_md[NW-1].x1));
                1:       a = SW'($signed(r_md[NW-1].y1));
                2:       a = SW'($signed(r_md[NW-1].x2));
                default: a = SW'($signed(r_md[NW-1].y2));
            endcase
            q = $signed({2'b00, w_quot[i]});
            if (r_md[NW-1].zero[i]) q = '0;
            else if (r_md[NW-1].neg[i]) q = -q;
            s = a + q;
            n_s[i] = s[SW-1] ? s + SW'(1) : s;
        end
    end

    // Stage B2: pick the border crossing per endpoint; a corner tries the
    // horizontal border and falls back to the vertical one.
    always_comb begin
        logic [3:0]           c;
        logic signed [SW-1:0] bh;
        logic signed [SW-1:0] bv;
        logic signed [SW-1:0] sh;
        logic signed [SW-1:0] sv;
        logic signed [SW-1:0] x0;
        logic signed [SW-1:0] y0;
        for (int e = 0; e < 2; e++) begin
            c  = (e == 0) ? r_mb1.c1 : r_mb1.c2;
            x0 = (e == 0) ? SW'($signed(r_mb1.x1)) : SW'($signed(r_mb1.x2));
            y0 = (e == 0) ? SW'($signed(r_mb1.y1)) : SW'($signed(r_mb1.y2));
            bh = f_ext_sw(c[CN] ? w_win.top : w_win.bottom);
            bv = f_ext_sw(c[CWB] ? w_win.left : w_win.right);
            sh = r_s[2*e];
            sv = r_s[2*e+1];
            priority if ((c[CN] || c[CS]) && (c[CWB] || c[CE]) &&
                         (sh < f_ext_sw(w_win.left) || sh > f_ext_sw(w_win.right))) begin
                n_px[e] = bv;
                n_py[e] = sv;
            end else if (c[CN] || c[CS]) begin
                n_px[e] = sh;
                n_py[e] = bh;
            end else if (c[CWB] || c[CE]) begin
                n_px[e] = bv;
                n_py[e] = sv;
            end else begin
                n_px[e] = x0;
                n_py[e] = y0;
            end
        end
    end

    // Stage B3: trivial accept, shared-bit reject, or both moved points inside.
    always_comb begin
        n_vis = ((r_mb2.c1 & r_mb2.c2) == 4'b0) &&
                (((r_mb2.c1 == 4'b0) && (r_mb2.c2 == 4'b0)) ||
                 (f_inside(r_px[0], r_py[0], w_win) && f_inside(r_px[1], r_py[1], w_win)));
        if (n_vis) begin
            n_o[0] = r_px[0][W-1:0];
            n_o[1] = r_py[0][W-1:0];
            n_o[2] = r_px[1][W-1:0];
            n_o[3] = r_py[1][W-1:0];
        end else begin
            n_o[0] = r_mb2.x1;
            n_o[1] = r_mb2.y1;
            n_o[2] = r_mb2.x2;
            n_o[3] = r_mb2.y2;
        end
    end

    // Payload registers: advance with the pipeline, no reset.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1  <= n_m1;
            r_m2  <= r_m1;
            r_nh1 <= n_nh1;
            r_nh2 <= n_nh2;
            r_nv1 <= n_nv1;
            r_nv2 <= n_nv2;
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_m3  <= r_m2;
            r_dx3 <= r_dx;
            r_dy3 <= r_dy;
            r_m4  <= n_m4;
            r_dmx <= EW'(r_dx3[EW-1] ? -r_dx3 : r_dx3);
            r_dmy <= EW'(r_dy3[EW-1] ? -r_dy3 : r_dy3);
            for (int i = 0; i < 4; i++) begin
                r_p[i]   <= w_p[i];
                r_mag[i] <= n_mag[i];
                r_s[i]   <= n_s[i];
                r_o[i]   <= n_o[i];
            end
            r_md[0] <= r_m4;
            for (int i = 1; i < NW; i++) begin
                r_md[i] <= r_md[i-1];
            end
            r_mb1 <= r_md[NW-1];
            r_mb2 <= r_mb1;
            for (int e = 0; e < 2; e++) begin
                r_px[e] <= n_px[e];
                r_py[e] <= n_py[e];
            end
            r_vis <= n_vis;
            r_c1o <= r_mb2.c1;
            r_c2o <= r_mb2.c2;
        end
    end

    assign o_clip.valid           = r_out_valid;
    assign o_clip.visible         = r_vis;
    assign o_clip.clipped_start_x = r_o[0];
    assign o_clip.clipped_start_y = r_o[1];
    assign o_clip.clipped_end_x   = r_o[2];
    assign o_clip.clipped_end_y   = r_o[3];

    `LC_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_seg.valid && i_seg.ready, r_v1, "accepted word did not enter stage one")
    `LC_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_vb2 && !w_en, r_vb2 && $stable(r_mb2), "pipeline moved during stall")
    `LC_ASSERT_IMP(a_trivial_accept, i_clk, i_rst_n, o_clip.valid && (r_c1o == 4'b0) && (r_c2o == 4'b0), o_clip.visible, "inside segment not visible")
    `LC_ASSERT_IMP(a_shared_reject, i_clk, i_rst_n, o_clip.valid && ((r_c1o & r_c2o) != 4'b0), !o_clip.visible, "shared outcode bit not rejected")
    `LC_ASSERT_NXT_NR(a_reset_empty, i_clk, !i_rst_n, !o_clip.valid, "output valid after reset")
endmodule

// File: hdl/lc_apb_regs.sv
// APB window registers of the line clipper.
module lc_apb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [lc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [lc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                               pready,
    output lc_pkg::t_window                    o_win
);
    localparam int PAD = lc_pkg::APB_DATA_BITS - lc_pkg::WIN_BITS;

    lc_pkg::t_window             r_win;
    lc_pkg::t_reg_idx            w_idx;
    logic [lc_pkg::WIN_BITS-1:0] w_rd;
    logic [lc_pkg::WIN_BITS-1:0] w_wd;

    assign w_idx  = lc_pkg::t_reg_idx'(paddr[lc_pkg::APB_ADDR_BITS-1:2]);
    assign w_wd   = pwdata[lc_pkg::WIN_BITS-1:0];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= lc_pkg::LEFT_RST;
            r_win.right  <= lc_pkg::RIGHT_RST;
            r_win.top    <= lc_pkg::TOP_RST;
            r_win.bottom <= lc_pkg::BOTTOM_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                lc_pkg::REG_LEFT:   r_win.left   <= w_wd;
                lc_pkg::REG_RIGHT:  r_win.right  <= w_wd;
                lc_pkg::REG_TOP:    r_win.top    <= w_wd;
                lc_pkg::REG_BOTTOM: r_win.bottom <= w_wd;
                default:            r_win        <= r_win;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lc_pkg::REG_LEFT:   w_rd = r_win.left;
            lc_pkg::REG_RIGHT:  w_rd = r_win.right;
            lc_pkg::REG_TOP:    w_rd = r_win.top;
            lc_pkg::REG_BOTTOM: w_rd = r_win.bottom;
            default:            w_rd = '0;
        endcase
    end

    assign prdata = {{PAD{1'b0}}, w_rd};
    assign o_win  = r_win;
endmodule

// File: hdl/lc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module lc_div_pipe #(
    parameter int NUM_BITS = 35,
    parameter int DEN_BITS = 17
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [NUM_BITS-1:0] o_quot
);
    logic [DEN_BITS-1:0] r_rem [NUM_BITS];
    logic [NUM_BITS-1:0] r_nq  [NUM_BITS];
    logic [DEN_BITS-1:0] r_den [NUM_BITS];

    genvar s;
    for (s = 0; s < NUM_BITS; s++) begin : g_stage
        logic [DEN_BITS-1:0] w_rem_in;
        logic [DEN_BITS-1:0] w_den_in;
        logic [NUM_BITS-1:0] w_nq_in;
        logic [DEN_BITS:0]   w_trial;
        logic [DEN_BITS:0]   w_diff;
        logic                w_bit;

        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_nq_in  = i_num;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_nq_in  = r_nq[s-1];
            assign w_den_in = r_den[s-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign w_trial = {w_rem_in, w_nq_in[NUM_BITS-1]};
        assign w_diff  = w_trial - {1'b0, w_den_in};
        assign w_bit   = (w_trial >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_bit ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
                r_nq[s]  <= {w_nq_in[NUM_BITS-2:0], w_bit};
                r_den[s] <= w_den_in;
            end
        end
    end

    assign o_quot = r_nq[NUM_BITS-1];
endmodule
